### rtl/tfd_pkg.sv
`default_nettype none

package tfd_pkg;

  // Configuration register indexes.
  localparam logic RegOutputEnable  = 1'b0;
  localparam logic RegThreeQuarters = 1'b1;

  // Result character kinds.
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindData = 2'd1;
  localparam logic [1:0] KindName = 2'd2;

  // Escape sequence steps.
  localparam logic [2:0] EscIdle   = 3'd0;
  localparam logic [2:0] EscLetter = 3'd1;
  localparam logic [2:0] EscArg    = 3'd2;
  localparam logic [2:0] EscTens   = 3'd3;
  localparam logic [2:0] EscUnits  = 3'd4;

  // Fixed character codes.
  localparam logic [6:0] BarCode   = 7'd124;
  localparam logic [6:0] SpaceCode = 7'd32;
  localparam logic [6:0] CrCode    = 7'd13;
  localparam logic [6:0] DigitZero = 7'd48;

  // Control letters.
  localparam logic [6:0] LetShift0 = 7'h30;
  localparam logic [6:0] LetShift1 = 7'h31;
  localparam logic [6:0] LetShift2 = 7'h32;
  localparam logic [6:0] LetShift3 = 7'h33;
  localparam logic [6:0] LetShift4 = 7'h34;
  localparam logic [6:0] LetShift5 = 7'h35;
  localparam logic [6:0] LetA      = 7'h41;
  localparam logic [6:0] LetD      = 7'h44;
  localparam logic [6:0] LetE      = 7'h45;
  localparam logic [6:0] LetF      = 7'h46;
  localparam logic [6:0] LetG      = 7'h47;
  localparam logic [6:0] LetI      = 7'h49;
  localparam logic [6:0] LetL      = 7'h4C;
  localparam logic [6:0] LetT      = 7'h54;
  localparam logic [6:0] LetZ      = 7'h5A;

  // Shift offsets, modulo 256.
  localparam logic [7:0] Shift0 = 8'h00;
  localparam logic [7:0] Shift1 = 8'hC0;
  localparam logic [7:0] Shift2 = 8'd64;
  localparam logic [7:0] Shift3 = 8'd96;
  localparam logic [7:0] Shift4 = 8'd128;
  localparam logic [7:0] Shift5 = 8'd160;

  // Checksum digit weights.
  localparam logic [14:0] WeightHundreds = 15'd100;
  localparam logic [14:0] WeightTens     = 15'd10;

  localparam logic [6:0] ThreeQuartersReset = 7'd125;

  typedef struct packed {
    logic [1:0]  char_kind;
    logic [7:0]  char_value;
    logic        parity_bad;
    logic        frame_done;
    logic        checksum_bad;
    logic        file_ended;
    logic        header_ready;
    logic [15:0] frame_count;
  } res_t;

endpackage

`default_nettype wire

### rtl/tfd_if.sv
`default_nettype none

interface tfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       block_end;

  modport source (output valid, rx_byte, block_end, input ready);
  modport sink (input valid, rx_byte, block_end, output ready);
endinterface

interface tfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  char_kind;
  logic [7:0]  char_value;
  logic        parity_bad;
  logic        frame_done;
  logic        checksum_bad;
  logic        file_ended;
  logic        header_ready;
  logic [15:0] frame_count;

  modport source (output valid, char_kind, char_value, parity_bad, frame_done,
                  checksum_bad, file_ended, header_ready, frame_count, input ready);
  modport sink (input valid, char_kind, char_value, parity_bad, frame_done,
                checksum_bad, file_ended, header_ready, frame_count, output ready);
endinterface

interface tfd_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/telesoftware_frame_decoder_core.sv
// Telesoftware frame decoder: one received modem byte in, one result out.
// The rx_i channel carries the received byte (bit 7 is even parity) and a
// block_end mark; every accepted transaction yields exactly one transaction
// on res_o, holding the decoded character (if any) and the status flags.
// The result is registered at the edge that accepts the byte. Throughput
// is one byte per cycle while res_o is ready; the whole decode step is a
// single pass of logic from the decoder state and input to the result
// register. rx_i is ready whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result and
// stops input after one byte.
// cfg_i writes output_enable (index 0) and three_quarters_code (index 1);
// it is always ready and is meant to be written while the block is idle.
// Reset clears all decoder state, sets the three-quarters code to 125 and
// arms the block flags to clear on the first byte.
`default_nettype none

module telesoftware_frame_decoder_core import tfd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tfd_cfg_if.sink    cfg_i,
  tfd_rx_if.sink     rx_i,
  tfd_res_if.source  res_o
);

  logic        oe_q;
  logic [6:0]  tq_q;

  logic [2:0]  step_q, step_d;
  logic [6:0]  letter_q, letter_d;
  logic [7:0]  shift_q, shift_d;
  logic        inside_q, inside_d;
  logic        skip_q, skip_d;
  logic [15:0] frame_q, frame_d;
  logic [6:0]  xor_q, xor_d;
  logic [14:0] sum_q, sum_d;
  logic        eof_q, eof_d;
  logic        mismatch_q, mismatch_d;
  logic        par_flag_q, par_flag_d;
  logic        frm_flag_q, frm_flag_d;
  logic        clear_q, clear_d;

  logic        out_valid_q;
  res_t        res_q, res_d;

  logic        rx_fire;
  logic [6:0]  b;
  logic [14:0] digit;
  logic [1:0]  kind;
  logic [7:0]  val;
  logic [6:0]  data_char;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oe_q <= 1'b0;
      tq_q <= ThreeQuartersReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegOutputEnable:  oe_q <= cfg_i.data[0];
        RegThreeQuarters: tq_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  assign b         = rx_i.rx_byte[6:0];
  assign digit     = 15'(b) - 15'(DigitZero);
  assign data_char = (b == tq_q) ? SpaceCode : b;

  always_comb begin
    step_d     = step_q;
    letter_d   = letter_q;
    shift_d    = shift_q;
    inside_d   = inside_q;
    skip_d     = skip_q;
    frame_d    = frame_q;
    xor_d      = xor_q;
    sum_d      = sum_q;
    eof_d      = eof_q;
    mismatch_d = mismatch_q;
    par_flag_d = par_flag_q;
    frm_flag_d = frm_flag_q;
    kind       = KindNone;
    val        = 8'd0;

    if (clear_q) begin
      par_flag_d = 1'b0;
      frm_flag_d = 1'b0;
    end
    clear_d = rx_i.block_end;

    if (inside_q && ^rx_i.rx_byte) begin
      par_flag_d = 1'b1;
    end

    if (b == BarCode) begin
      step_d = EscLetter;
    end else if (inside_q && step_q == EscIdle) begin
      xor_d = xor_q ^ b;
      if (!skip_q) begin
        if (frame_q == 16'd1) begin
          if (letter_q == LetI) begin
            kind = KindName;
            val  = {1'b0, b};
          end
        end else if (oe_q) begin
          kind = KindData;
          val  = 8'({1'b0, data_char} + {1'b0, shift_q});
        end
      end
    end else if (step_q != EscIdle) begin
      // The bar and the letter count toward the checksum, except for A and Z.
      if (step_q == EscLetter) begin
        letter_d = b;
        if (b != LetA && b != LetZ) begin
          xor_d = xor_q ^ BarCode ^ b;
        end
      end
      unique case (letter_d) inside
        LetShift0: begin shift_d = Shift0; step_d = EscIdle; end
        LetShift1: begin shift_d = Shift1; step_d = EscIdle; end
        LetShift2: begin shift_d = Shift2; step_d = EscIdle; end
        LetShift3: begin shift_d = Shift3; step_d = EscIdle; end
        LetShift4: begin shift_d = Shift4; step_d = EscIdle; end
        LetShift5: begin shift_d = Shift5; step_d = EscIdle; end
        LetA: begin
          frame_d  = frame_q + 16'd1;
          xor_d    = 7'd0;
          step_d   = EscIdle;
          inside_d = 1'b1;
        end
        LetD, LetT: step_d = EscIdle;
        LetE: begin
          if (oe_q) begin
            kind = KindData;
            val  = 8'({1'b0, BarCode} + {1'b0, shift_q});
          end
          step_d = EscIdle;
        end
        LetF: begin
          eof_d    = 1'b1;
          step_d   = EscIdle;
          inside_d = 1'b0;
        end
        LetG: begin
          if (step_q == EscLetter) begin
            step_d = EscArg;
          end else if (step_q == EscArg) begin
            xor_d  = xor_d ^ b;
            step_d = EscIdle;
            skip_d = 1'b1;
          end
        end
        LetI: begin
          skip_d = 1'b0;
          step_d = EscIdle;
        end
        LetL: begin
          step_d = EscIdle;
          if (frame_q == 16'd1) begin
            skip_d = 1'b1;
          end else if (oe_q) begin
            kind = KindData;
            val  = {1'b0, CrCode};
          end
        end
        LetZ: begin
          if (step_q == EscLetter) begin
            sum_d    = 15'd0;
            step_d   = EscArg;
            inside_d = 1'b0;
          end else if (step_q == EscArg) begin
            sum_d  = sum_q + 15'(digit * WeightHundreds);
            step_d = EscTens;
          end else if (step_q == EscTens) begin
            sum_d  = sum_q + 15'(digit * WeightTens);
            step_d = EscUnits;
          end else if (step_q == EscUnits) begin
            sum_d = sum_q + digit;
            if (sum_d != {8'd0, xor_q}) begin
              mismatch_d = 1'b1;
            end
            step_d     = EscIdle;
            frm_flag_d = 1'b1;
          end
        end
        default: begin
          // A fixed letter takes precedence over the three-quarters code.
          if (letter_d == tq_q) begin
            if (oe_q) begin
              kind = KindData;
              val  = 8'({1'b0, tq_q} + {1'b0, shift_q});
            end
          end else begin
            skip_d = 1'b1;
          end
          step_d = EscIdle;
        end
      endcase
    end

    res_d.char_kind    = kind;
    res_d.char_value   = val;
    res_d.parity_bad   = par_flag_d;
    res_d.frame_done   = frm_flag_d;
    res_d.checksum_bad = mismatch_d;
    res_d.file_ended   = eof_d;
    res_d.header_ready = (frame_d == 16'd1);
    res_d.frame_count  = frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= EscIdle;
      letter_q   <= 7'd0;
      shift_q    <= 8'd0;
      inside_q   <= 1'b0;
      skip_q     <= 1'b0;
      frame_q    <= 16'd0;
      xor_q      <= 7'd0;
      sum_q      <= 15'd0;
      eof_q      <= 1'b0;
      mismatch_q <= 1'b0;
      par_flag_q <= 1'b0;
      frm_flag_q <= 1'b0;
      clear_q    <= 1'b1;
    end else if (rx_fire) begin
      step_q     <= step_d;
      letter_q   <= letter_d;
      shift_q    <= shift_d;
      inside_q   <= inside_d;
      skip_q     <= skip_d;
      frame_q    <= frame_d;
      xor_q      <= xor_d;
      sum_q      <= sum_d;
      eof_q      <= eof_d;
      mismatch_q <= mismatch_d;
      par_flag_q <= par_flag_d;
      frm_flag_q <= frm_flag_d;
      clear_q    <= clear_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.char_kind    = res_q.char_kind;
  assign res_o.char_value   = res_q.char_value;
  assign res_o.parity_bad   = res_q.parity_bad;
  assign res_o.frame_done   = res_q.frame_done;
  assign res_o.checksum_bad = res_q.checksum_bad;
  assign res_o.file_ended   = res_q.file_ended;
  assign res_o.header_ready = res_q.header_ready;
  assign res_o.frame_count  = res_q.frame_count;

endmodule

`default_nettype wire

### rtl/tfd_checker.sv
`default_nettype none

module tfd_checker import tfd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_valid_i,
  input wire logic        rx_ready_i,
  input wire logic        res_valid_i,
  input wire logic [1:0]  char_kind_i,
  input wire logic [7:0]  char_value_i,
  input wire logic        header_ready_i,
  input wire logic [15:0] frame_count_i
);

  // Every accepted byte shows up as a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_i |=> res_valid_i)
    else $error("result missing after accepted byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> char_kind_i <= KindName)
    else $error("illegal character kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && char_kind_i == KindNone |-> char_value_i == 8'd0)
    else $error("character value set without a character");

  // Filename characters only come out of the header frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && char_kind_i == KindName |-> header_ready_i && !char_value_i[7])
    else $error("filename character outside the header frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> header_ready_i == (frame_count_i == 16'd1))
    else $error("header flag disagrees with frame count");

endmodule

bind telesoftware_frame_decoder_core tfd_checker u_tfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_valid_i     (rx_i.valid),
  .rx_ready_i     (rx_i.ready),
  .res_valid_i    (res_o.valid),
  .char_kind_i    (res_o.char_kind),
  .char_value_i   (res_o.char_value),
  .header_ready_i (res_o.header_ready),
  .frame_count_i  (res_o.frame_count)
);

`default_nettype wire
